### hw/rtl/last_note_priority_stack_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the last-note-priority stack
// Shared concurrent assertion forms, all disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef LAST_NOTE_PRIORITY_STACK_ASSERT_SVH
`define LAST_NOTE_PRIORITY_STACK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNPS_ASSERT_IMPLY(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LNPS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

// The condition must hold in every cycle out of reset.
`define LNPS_ASSERT_ALWAYS(label, clock, reset, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error(msg);

`endif

### hw/rtl/lnps_pkg.sv
// ----------------------------------------------------------------------------
// lnps_pkg
// Types and constants shared by the last-note-priority stack and its cells.
// ----------------------------------------------------------------------------
package lnps_pkg;

  localparam int POOL_DEPTH = 8;
  localparam int DEPTH_W    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int CMD_W      = 2;
  localparam int SLOT_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [NOTE_W-1:0]     note_number;
    logic [VEL_W-1:0]      note_velocity;
    logic [SLOT_IDX_W-1:0] slot_index;
  } lnps_in_t;

  typedef struct packed {
    logic [NOTE_W-1:0] held_note;
    logic              any_held;
    logic              slot_valid;
    logic [NOTE_W-1:0] slot_note;
    logic [VEL_W-1:0]  slot_velocity;
    logic              release_found;
  } lnps_out_t;

  typedef struct packed {
    logic              flag;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } lnps_slot_t;

  typedef struct packed {
    logic              push;
    logic              pull;
    logic [NOTE_W-1:0] key;
  } lnps_ctrl_t;

  localparam lnps_slot_t EMPTY_SLOT = '{flag: 1'b0, note: '0, velocity: '0};

endpackage

### hw/rtl/last_note_priority_stack.sv
// ----------------------------------------------------------------------------
// last_note_priority_stack
// Last-note-priority note stack built as a chain of slot cells.
// ----------------------------------------------------------------------------
// A transaction is accepted at the edge where start is high and busy is low;
// the cell chain updates at that edge, and in the next cycle the result is on
// the result port with done high for that one cycle, read from the updated
// stack. Busy is high during the result cycle, so no new transaction is
// accepted until the result has been given. The receiver cannot stall:
// a result must be taken in the cycle done is high.
`include "last_note_priority_stack_assert.svh"

module last_note_priority_stack
  import lnps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  lnps_in_t  request,
  output logic      busy,
  output logic      done,
  output lnps_out_t result
);

  localparam int CMP_W = ((DEPTH_W > SLOT_IDX_W) ? DEPTH_W : SLOT_IDX_W) + 1;

  logic       accept;
  lnps_ctrl_t ctrl;
  lnps_slot_t slots      [POOL_DEPTH];
  lnps_slot_t slots_next [POOL_DEPTH];
  logic       match      [POOL_DEPTH+1];
  logic [POOL_DEPTH-1:0] flags;

  logic                  pending;
  logic                  found;
  logic [SLOT_IDX_W-1:0] index;
  logic [NOTE_W-1:0]     sounding_note;
  logic [NOTE_W-1:0]     sounding_note_next;

  logic [CMP_W-1:0]   index_ext;
  logic               in_range;
  logic [DEPTH_W-1:0] sel;

  assign accept    = start && !busy;
  assign ctrl.push = accept && (request.cmd == CMD_NOTE_ON);
  assign ctrl.pull = accept && (request.cmd == CMD_NOTE_OFF);
  assign ctrl.key  = request.note_number;
  assign match[0]  = 1'b0;

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    lnps_slot_t upper;
    lnps_slot_t lower;

    if (i == 0) begin : g_top
      assign upper = '{flag: 1'b1, note: request.note_number,
                       velocity: request.note_velocity};
    end else begin : g_mid
      assign upper = slots[i-1];
    end

    if (i == POOL_DEPTH - 1) begin : g_bottom
      assign lower = EMPTY_SLOT;
    end else begin : g_inner
      assign lower = slots[i+1];
    end

    lnps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .upper     (upper),
      .lower     (lower),
      .match_in  (match[i]),
      .match_out (match[i+1]),
      .slot      (slots[i]),
      .slot_next (slots_next[i])
    );

    assign flags[i] = slots[i].flag;
  end

  always_comb begin
    sounding_note_next = sounding_note;
    if (ctrl.push) begin
      sounding_note_next = request.note_number;
    end else if (ctrl.pull && match[POOL_DEPTH]) begin
      sounding_note_next = slots_next[0].flag ? slots_next[0].note : slots[0].note;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      found         <= 1'b0;
      index         <= '0;
      sounding_note <= '0;
    end else begin
      pending       <= accept;
      sounding_note <= sounding_note_next;
      if (accept) begin
        found <= ctrl.pull && match[POOL_DEPTH];
        index <= request.slot_index;
      end
    end
  end

  assign busy = pending;
  assign done = pending;

  assign index_ext = CMP_W'(index);
  assign in_range  = index_ext < CMP_W'(POOL_DEPTH);
  assign sel       = index_ext[DEPTH_W-1:0];

  always_comb begin
    result.held_note     = sounding_note;
    result.any_held      = slots[0].flag;
    result.release_found = found;
    if (in_range) begin
      result.slot_valid    = slots[sel].flag;
      result.slot_note     = slots[sel].note;
      result.slot_velocity = slots[sel].velocity;
    end else begin
      result.slot_valid    = 1'b0;
      result.slot_note     = '0;
      result.slot_velocity = '0;
    end
  end

  `LNPS_ASSERT_NEXT(a_result_follows, clk, rst, accept, done, "result missing after accept")
  `LNPS_ASSERT_NEXT(a_single_result, clk, rst, done, !done, "result held for two cycles")
  `LNPS_ASSERT_NEXT(a_push_sounds, clk, rst, ctrl.push,
    result.any_held && (result.held_note == $past(request.note_number)),
    "note on did not become the held note")
  `LNPS_ASSERT_NEXT(a_miss_keeps_pitch, clk, rst, ctrl.pull,
    result.release_found || $stable(sounding_note), "unmatched note off changed the pitch")
  `LNPS_ASSERT_ALWAYS(a_packed_stack, clk, rst,
    $onehot({1'b0, flags} + {{POOL_DEPTH{1'b0}}, 1'b1}), "occupied slots are not contiguous")

endmodule

### hw/rtl/lnps_cell.sv
// ----------------------------------------------------------------------------
// lnps_cell
// One stack slot. On a push it takes the slot above; on a pull at or below
// the first matching slot it takes the slot below.
// ----------------------------------------------------------------------------
module lnps_cell
  import lnps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lnps_ctrl_t ctrl,
  input  lnps_slot_t upper,
  input  lnps_slot_t lower,
  input  logic       match_in,
  output logic       match_out,
  output lnps_slot_t slot,
  output lnps_slot_t slot_next
);

  logic hit;

  assign hit       = slot.flag && (slot.note == ctrl.key);
  assign match_out = match_in || hit;

  always_comb begin
    slot_next = slot;
    if (ctrl.push) begin
      slot_next = upper;
    end else if (ctrl.pull && match_out) begin
      slot_next = lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= EMPTY_SLOT;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

### tb/last_note_priority_stack_checker.sv
// ----------------------------------------------------------------------------
// last_note_priority_stack_checker
// Watches the command and result channels of the note stack. It keeps its own
// copy of the eight slots and the sounding pitch, predicts the result of every
// accepted transaction and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module last_note_priority_stack_checker
  import lnps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  lnps_in_t  request,
  input  logic      done,
  input  lnps_out_t result,
  output int        mismatches,
  output int        outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  lnps_slot_t        slots [POOL_DEPTH];
  logic [NOTE_W-1:0] sounding;
  lnps_out_t         expected_results [$];

  function automatic lnps_out_t play_event(lnps_in_t ev);
    lnps_out_t  r;
    lnps_slot_t old_top;
    int         hit;
    int         i;
    r       = '0;
    hit     = -1;
    old_top = slots[0];
    case (ev.cmd)
      CMD_NOTE_ON: begin
        for (i = POOL_DEPTH - 1; i > 0; i--) slots[i] = slots[i-1];
        slots[0] = '{flag: 1'b1, note: ev.note_number, velocity: ev.note_velocity};
        sounding = ev.note_number;
      end
      CMD_NOTE_OFF: begin
        for (i = 0; i < POOL_DEPTH; i++) begin
          if (hit < 0 && slots[i].flag && slots[i].note == ev.note_number) hit = i;
        end
        if (hit >= 0) begin
          for (i = hit; i < POOL_DEPTH - 1; i++) slots[i] = slots[i+1];
          slots[POOL_DEPTH-1] = EMPTY_SLOT;
          sounding = slots[0].flag ? slots[0].note : old_top.note;
          r.release_found = 1'b1;
        end
      end
      default: ;
    endcase
    r.held_note = sounding;
    r.any_held  = slots[0].flag;
    if (int'(ev.slot_index) < POOL_DEPTH) begin
      r.slot_valid    = slots[ev.slot_index].flag;
      r.slot_note     = slots[ev.slot_index].note;
      r.slot_velocity = slots[ev.slot_index].velocity;
    end
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    lnps_out_t want;
    if (rst) begin
      for (int i = 0; i < POOL_DEPTH; i++) slots[i] = EMPTY_SLOT;
      sounding = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, result);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("held_note", want.held_note, result.held_note);
          compare_field("any_held", want.any_held, result.any_held);
          compare_field("slot_valid", want.slot_valid, result.slot_valid);
          compare_field("slot_note", want.slot_note, result.slot_note);
          compare_field("slot_velocity", want.slot_velocity, result.slot_velocity);
          compare_field("release_found", want.release_found, result.release_found);
        end
      end
      if (start && !busy) expected_results.push_back(play_event(request));
    end
    outstanding = expected_results.size();
  end

endmodule

### tb/last_note_priority_stack_test.sv
// ----------------------------------------------------------------------------
// last_note_priority_stack_test
// Drives note on, note off, read and spare command transactions into the
// note stack: a directed opening over the edge cases, then blocks of random
// traffic built around small note pools so that releases often match. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module last_note_priority_stack_test
  import lnps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BLOCKS = 16;
  localparam int BLOCK_ITEMS = 50;

  logic      clk;
  logic      rst;
  logic      start;
  lnps_in_t  request;
  logic      busy;
  logic      done;
  lnps_out_t result;
  int        mismatches;
  int        outstanding;
  int        idle_cycles;
  bit        gaps_on;

  last_note_priority_stack dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  last_note_priority_stack_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("last_note_priority_stack regression: fail");
        $finish;
      end
    end
  end

  task automatic play(logic [CMD_W-1:0] cmd, int note, int vel, int idx);
    int gap;
    start   <= 1'b1;
    request <= '{cmd: cmd, note_number: note[NOTE_W-1:0],
                 note_velocity: vel[VEL_W-1:0], slot_index: idx[SLOT_IDX_W-1:0]};
    do @(posedge clk); while (busy);
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int on_weight;
    int pool_base;
    int sel;
    int note;
    start   <= 1'b0;
    request <= '0;
    rst     <= 1'b1;
    gaps_on  = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    play(CMD_READ, 0, 0, 0);
    play(CMD_NOTE_OFF, 60, 0, 0);
    play(CMD_NOTE_ON, 0, 0, 0);
    play(CMD_NOTE_ON, 127, 127, 1);
    play(CMD_NOTE_OFF, 0, 5, 1);
    play(CMD_NOTE_OFF, 127, 9, 0);
    play(CMD_READ, 127, 127, 7);
    for (int i = 0; i < 9; i++) play(CMD_NOTE_ON, 10 + i, 100 + i, i % 8);
    play(CMD_NOTE_OFF, 10, 0, 7);
    play(CMD_NOTE_ON, 14, 64, 0);
    play(CMD_NOTE_OFF, 14, 0, 5);
    play(CMD_SPARE, 14, 127, 7);
    play(CMD_READ, 0, 0, 3);
    drain();

    for (int b = 0; b < BLOCKS; b++) begin
      gaps_on   = ($urandom_range(0, 2) != 0);
      on_weight = $urandom_range(30, 75);
      pool_base = $urandom_range(0, 120);
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        sel  = $urandom_range(0, 99);
        note = ($urandom_range(0, 4) != 0) ? pool_base + $urandom_range(0, 7)
                                           : $urandom_range(0, 127);
        if (sel < 6)
          play($urandom_range(0, 1) ? CMD_READ : CMD_SPARE, $urandom_range(0, 127),
               $urandom_range(0, 127), $urandom_range(0, 7));
        else if (sel < 6 + on_weight)
          play(CMD_NOTE_ON, note, $urandom_range(0, 127), $urandom_range(0, 7));
        else
          play(CMD_NOTE_OFF, note, $urandom_range(0, 127), $urandom_range(0, 7));
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("last_note_priority_stack regression: pass");
    end else begin
      $display("last_note_priority_stack regression: fail");
    end
    $finish;
  end

endmodule
